/* design/sts_pkg.sv */
// Shared types and constants for the script token scanner.
// Packed payload structs, token kind codes, character codes and class functions.
// No dependencies.
package sts_pkg;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } scan_in_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [31:0] token_start;
        logic [31:0] token_length;
        logic [62:0] number_value;
        logic        last_of_run;
    } scan_tok_t;

    localparam logic [3:0] K_IF     = 4'd0;
    localparam logic [3:0] K_THEN   = 4'd1;
    localparam logic [3:0] K_ELSE   = 4'd2;
    localparam logic [3:0] K_END    = 4'd3;
    localparam logic [3:0] K_IDENT  = 4'd4;
    localparam logic [3:0] K_NUMBER = 4'd5;
    localparam logic [3:0] K_STRING = 4'd6;
    localparam logic [3:0] K_NEQ    = 4'd7;
    localparam logic [3:0] K_ASSIGN = 4'd8;
    localparam logic [3:0] K_DOT    = 4'd9;
    localparam logic [3:0] K_COMMA  = 4'd10;
    localparam logic [3:0] K_LPAREN = 4'd11;
    localparam logic [3:0] K_RPAREN = 4'd12;
    localparam logic [3:0] K_EOF    = 4'd13;
    localparam logic [3:0] K_ERROR  = 4'd14;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    // Lower-case keyword text, first byte in the low byte
    localparam logic [31:0] KW_IF   = 32'h0000_6669;
    localparam logic [31:0] KW_THEN = 32'h6E65_6874;
    localparam logic [31:0] KW_ELSE = 32'h6573_6C65;
    localparam logic [31:0] KW_END  = 32'h0064_6E65;

    localparam logic [62:0] NUM_MAX = {63{1'b1}};
    localparam logic [31:0] LEN_MAX = {32{1'b1}};

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == CH_UNDER;
    endfunction

endpackage

/* design/script_token_scanner_top.sv */
// Script token scanner: byte-serial lexer for a small BASIC-like language.
// Depends on sts_pkg (payload structs, kind codes, character classes).
//
// Takes one text byte per transfer and delivers tokens (kind, start, length,
// number value). An input transfer is taken into an input register; from there
// combinational logic updates the scanner state and loads the result register,
// which holds the up to two tokens that the byte causes. Results leave one per
// cycle while out_ready is high, so a byte giving one token or none sustains one
// byte per cycle; a byte giving two (a token closed by a delimiter or error
// token, or by end of input) holds off the next byte while both are held. Each
// byte passes the input register and then the result register. After an eof
// or error token all input is taken and dropped until reset.
module script_token_scanner_top #(
    parameter int POSITION_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sts_pkg::scan_in_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sts_pkg::scan_tok_t out_data
);
    import sts_pkg::*;

    typedef enum logic [2:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_STRING, M_COMMENT, M_LESS, M_DONE, M_ERROR
    } mode_t;

    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    function automatic logic [31:0] low32(input logic [POSITION_BITS-1:0] p);
        logic [63:0] w;
        w = 64'(p);
        return w[31:0];
    endfunction

    // input register
    logic     in_valid_reg;
    scan_in_t in_data_reg;

    // scanner state
    mode_t                    mode_reg, mode_next;
    logic [POSITION_BITS-1:0] position_reg, position_next;
    logic [POSITION_BITS-1:0] open_start_reg, open_start_next;
    logic [31:0]              open_length_reg, open_length_next;
    logic [62:0]              acc_reg, acc_next;
    logic [31:0]              prefix_reg, prefix_next;

    // result register: up to two tokens
    scan_tok_t  slot0_reg, slot1_reg;
    logic [1:0] count_reg;

    scan_tok_t  tok0, tok1, tok_close, tok_idle;
    logic [1:0] nres;
    logic       close_emit, idle_run, idle_emit;
    logic       process, can_load, out_fire;
    logic [7:0] c;
    logic       is_end;
    logic [66:0] acc_times10;
    logic [3:0]  kind_ident;

    assign c      = in_data_reg.text_byte;
    assign is_end = in_data_reg.end_of_text || (c == 8'h00);

    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot0_reg;
    assign out_fire  = out_valid && out_ready;
    assign can_load  = (count_reg == 2'd0) || (count_reg == 2'd1 && out_fire);
    assign process   = in_valid_reg && can_load;
    assign in_ready  = !in_valid_reg || process;

    assign acc_times10 = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                         + {63'b0, c[3:0]};

    always_comb
    begin
        kind_ident = K_IDENT;
        if (open_length_reg == 32'd2 && prefix_reg == KW_IF)
            kind_ident = K_IF;
        else if (open_length_reg == 32'd4 && prefix_reg == KW_THEN)
            kind_ident = K_THEN;
        else if (open_length_reg == 32'd4 && prefix_reg == KW_ELSE)
            kind_ident = K_ELSE;
        else if (open_length_reg == 32'd3 && prefix_reg == KW_END)
            kind_ident = K_END;
    end

    always_comb
    begin
        mode_next        = mode_reg;
        open_start_next  = open_start_reg;
        open_length_next = open_length_reg;
        acc_next         = acc_reg;
        prefix_next      = prefix_reg;
        position_next    = position_reg;
        tok_close        = '0;
        tok_idle         = '0;
        close_emit       = 1'b0;
        idle_run         = 1'b0;
        idle_emit        = 1'b0;

        tok_close.token_start  = low32(open_start_reg);
        tok_close.token_length = open_length_reg;

        unique case (mode_reg)
            M_DONE, M_ERROR: ;
            M_IDENT:
            begin
                if (!is_end && is_word(c))
                begin
                    if (open_length_reg < 32'd4)
                        prefix_next[8*open_length_reg[1:0] +: 8] =
                            is_alpha(c) ? (c | 8'h20) : c;
                    if (open_length_reg != LEN_MAX)
                        open_length_next = open_length_reg + 32'd1;
                end
                else
                begin
                    tok_close.token_kind = kind_ident;
                    close_emit = 1'b1;
                    idle_run   = 1'b1;
                end
            end
            M_NUMBER:
            begin
                if (!is_end && is_digit(c))
                begin
                    acc_next = (acc_times10 > {4'b0, NUM_MAX}) ? NUM_MAX : acc_times10[62:0];
                    if (open_length_reg != LEN_MAX)
                        open_length_next = open_length_reg + 32'd1;
                end
                else
                begin
                    tok_close.token_kind   = K_NUMBER;
                    tok_close.number_value = acc_reg;
                    close_emit = 1'b1;
                    idle_run   = 1'b1;
                end
            end
            M_STRING:
            begin
                tok_close.token_kind = K_STRING;
                if (is_end)
                begin
                    close_emit = 1'b1;
                    idle_run   = 1'b1;
                end
                else if (c == CH_DQUOTE)
                begin
                    close_emit = 1'b1;
                    mode_next  = M_IDLE;
                end
                else if (open_length_reg != LEN_MAX)
                    open_length_next = open_length_reg + 32'd1;
            end
            M_COMMENT:
            begin
                if (is_end)
                    idle_run = 1'b1;
                else if (c == CH_LF)
                    mode_next = M_IDLE;
            end
            M_LESS:
            begin
                close_emit = 1'b1;
                if (!is_end && c == CH_GT)
                begin
                    tok_close.token_kind   = K_NEQ;
                    tok_close.token_length = 32'd2;
                    mode_next = M_IDLE;
                end
                else
                begin
                    tok_close.token_kind   = K_ERROR;
                    tok_close.token_length = 32'd1;
                    mode_next = M_ERROR;
                end
            end
            default: idle_run = 1'b1;
        endcase

        // scan from the idle mode, possibly straight after closing a token
        if (idle_run)
        begin
            mode_next              = M_IDLE;
            tok_idle.token_start   = low32(position_reg);
            tok_idle.token_length  = 32'd1;
            if (is_end)
            begin
                tok_idle.token_kind   = K_EOF;
                tok_idle.token_length = 32'd0;
                idle_emit = 1'b1;
                mode_next = M_DONE;
            end
            else if (!(c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF))
            begin
                open_start_next  = position_reg;
                open_length_next = 32'd0;
                acc_next         = '0;
                prefix_next      = '0;
                if (c == CH_APOS)
                    mode_next = M_COMMENT;
                else if (is_alpha(c) || c == CH_UNDER)
                begin
                    prefix_next      = {24'b0, is_alpha(c) ? (c | 8'h20) : c};
                    open_length_next = 32'd1;
                    mode_next        = M_IDENT;
                end
                else if (is_digit(c))
                begin
                    acc_next         = {59'b0, c[3:0]};
                    open_length_next = 32'd1;
                    mode_next        = M_NUMBER;
                end
                else if (c == CH_DQUOTE)
                begin
                    open_start_next = position_reg + POS_ONE;
                    mode_next       = M_STRING;
                end
                else if (c == CH_LT)
                    mode_next = M_LESS;
                else
                begin
                    idle_emit = 1'b1;
                    case (c)
                        CH_EQ:     tok_idle.token_kind = K_ASSIGN;
                        CH_DOT:    tok_idle.token_kind = K_DOT;
                        CH_COMMA:  tok_idle.token_kind = K_COMMA;
                        CH_LPAREN: tok_idle.token_kind = K_LPAREN;
                        CH_RPAREN: tok_idle.token_kind = K_RPAREN;
                        default:
                        begin
                            tok_idle.token_kind = K_ERROR;
                            mode_next = M_ERROR;
                        end
                    endcase
                end
            end
        end

        if (!is_end && mode_reg != M_DONE && mode_reg != M_ERROR)
            position_next = position_reg + POS_ONE;
    end

    // pack the tokens into result order and mark the last one
    always_comb
    begin
        tok0 = tok_close;
        tok1 = tok_idle;
        nres = 2'({1'b0, close_emit} + {1'b0, idle_emit});
        if (!close_emit)
            tok0 = tok_idle;
        if (nres == 2'd2)
            tok1.last_of_run = 1'b1;
        else
            tok0.last_of_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            in_data_reg     <= '0;
            count_reg       <= 2'd0;
            slot0_reg       <= '0;
            slot1_reg       <= '0;
            mode_reg        <= M_IDLE;
            position_reg    <= '0;
            open_start_reg  <= '0;
            open_length_reg <= '0;
            acc_reg         <= '0;
            prefix_reg      <= '0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (in_ready && in_valid)
                in_data_reg <= in_data;
            if (process)
            begin
                mode_reg        <= mode_next;
                position_reg    <= position_next;
                open_start_reg  <= open_start_next;
                open_length_reg <= open_length_next;
                acc_reg         <= acc_next;
                prefix_reg      <= prefix_next;
                count_reg       <= nres;
                slot0_reg       <= tok0;
                slot1_reg       <= tok1;
            end
            else if (out_fire)
            begin
                count_reg <= count_reg - 2'd1;
                slot0_reg <= slot1_reg;
            end
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result count out of range");

    a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd2 |-> !slot0_reg.last_of_run && slot1_reg.last_of_run)
        else $error("token pair marked wrongly");

    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        process && (mode_reg == M_DONE || mode_reg == M_ERROR) |-> nres == 2'd0)
        else $error("token after eof or error");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == M_DONE || mode_reg == M_ERROR |=> $stable(mode_reg))
        else $error("left halted mode before reset");

    a_eof_done: assert property (@(posedge clk) disable iff (!rst_n)
        process && idle_emit && tok_idle.token_kind == K_EOF |=> mode_reg == M_DONE)
        else $error("eof without done mode");

endmodule
